@@ rtl/core/scan_curvature_assert.svh @@
// Assertion macros for scan_curvature.
`ifndef SCAN_CURVATURE_ASSERT_SVH
`define SCAN_CURVATURE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define SC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SC_ASSERT_IMPL(lbl, ante, cons, msg)
`define SC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/core/scurv_pkg.sv @@
`timescale 1ns / 1ps
package scurv_pkg;
  localparam int unsigned MA   = 37;  // multiplicand width
  localparam int unsigned MB   = 33;  // multiplier width
  localparam int unsigned PW   = MA + MB;
  localparam int unsigned RW   = 33;  // root width
  localparam int unsigned NW   = 69;  // dividend width
  localparam int unsigned DENW = 69;  // divisor width
  localparam int unsigned QW   = 34;  // quotient width

  localparam logic [16:0] SIN_C1 = 17'd102944;
  localparam logic [15:0] SIN_C2 = 16'd42047;
  localparam logic [15:0] SIN_C3 = 16'd4640;

  typedef struct packed {
    logic [15:0] u;
    logic        neg;
  } trig_t;
endpackage

@@ rtl/core/scurv_mul.sv @@
`timescale 1ns / 1ps
module scurv_mul (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [scurv_pkg::MA-1:0] a_i,
  input  logic [scurv_pkg::MB-1:0] b_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic [scurv_pkg::PW-1:0] prod_o
);
  import scurv_pkg::*;

  logic          busy_q;
  logic [PW-1:0] a_q, acc_q;
  logic [MB-1:0] b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && (b_q == '0)) begin
      busy_q <= 1'b0;
    end
  end

  // one multiplier bit per cycle, stops once the remaining bits are zero
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= {{(PW-MA){1'b0}}, a_i};
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q && (b_q != '0)) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

  assign busy_o = busy_q;
  assign done_o = busy_q && (b_q == '0);
  assign prod_o = acc_q;
endmodule

@@ rtl/core/scurv_sqrt.sv @@
`timescale 1ns / 1ps
module scurv_sqrt (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [63:0]              v_i,
  output logic                     done_o,
  output logic [scurv_pkg::RW-1:0] root_o
);
  import scurv_pkg::*;

  logic        busy_q;
  logic [63:0] v_q, res_q, bit_q, trial;

  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && (bit_q == '0)) begin
      busy_q <= 1'b0;
    end
  end

  // one root bit per cycle, 32 steps
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= v_i;
      res_q <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
    end else if (busy_q && (bit_q != '0)) begin
      if (v_q >= trial) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = busy_q && (bit_q == '0);
  assign root_o = res_q[RW-1:0];
endmodule

@@ rtl/core/scurv_div.sv @@
`timescale 1ns / 1ps
module scurv_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [scurv_pkg::NW-1:0]   num_i,
  input  logic [scurv_pkg::DENW-1:0] den_i,
  output logic                       done_o,
  output logic [scurv_pkg::QW-1:0]   quo_o
);
  import scurv_pkg::*;

  localparam int unsigned DSW = DENW + QW - 1;

  logic           busy_q, done_q;
  logic [5:0]     k_q;
  logic [NW-1:0]  rem_q;
  logic [DSW-1:0] dsh_q;
  logic [QW-1:0]  q_q;
  logic           ge;

  assign ge = {{(DSW-NW){1'b0}}, rem_q} >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && ((k_q == '0) || ((k_q == 6'(QW-1)) && ge))) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // restoring division, one quotient bit per cycle; the top step only flags overflow
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsh_q <= {den_i, {(QW-1){1'b0}}};
      q_q   <= '0;
      k_q   <= 6'(QW-1);
    end else if (busy_q) begin
      if (k_q == 6'(QW-1)) begin
        if (ge) begin
          q_q <= {1'b1, {(QW-1){1'b0}}};
        end
      end else if (ge) begin
        rem_q <= rem_q - dsh_q[NW-1:0];
        q_q   <= q_q | (QW'(1) << k_q);
      end
      dsh_q <= dsh_q >> 1;
      if (k_q != '0) begin
        k_q <= k_q - 6'd1;
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = q_q;
endmodule

@@ rtl/core/scan_curvature.sv @@
`timescale 1ns / 1ps
// scan_curvature: curvature of a lidar scan, one range sample per transaction.
// Input channel (in_valid_i / in_stall_o) carries range_i and first_i; first_i
// restarts the angle at a half turn and clears the differences. Output channel
// (out_valid_o / out_stall_i) returns one curvature_o (Q16.16) and
// saturated_o for every input transaction, in order.
// angle_step is written over the APB port at byte address 0. The user must
// write it only while idle; the block itself does not enforce this. One
// transaction at a time is worked on; the next input is taken in the cycle
// after the result is loaded. Each sample uses the shared bit-serial
// multiplier (up to 15 products, each stepping through multiplier bits
// until the remaining ones are zero), the square root and the divider.
// A finished result sits in the output register; the next input is taken
// while it waits, and a new result waits until the old one is taken, which
// holds in_stall_o high.
// Reset: angle_step = 64, phase = half turn, previous point and differences 0,
// output channel empty.
module scan_curvature #(
  parameter int unsigned TRIG_TABLE_DEPTH = 1024,
  parameter int unsigned PHASE_BITS       = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        range_i,
  input  logic               first_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] curvature_o,
  output logic               saturated_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import scurv_pkg::*;

  localparam int unsigned DB = $clog2(TRIG_TABLE_DEPTH);
  localparam int unsigned SW = (PHASE_BITS > 16) ? PHASE_BITS : 16;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_T_UU = 4'd1;
  localparam logic [3:0] ST_T_A  = 4'd2;
  localparam logic [3:0] ST_T_B  = 4'd3;
  localparam logic [3:0] ST_T_C  = 4'd4;
  localparam logic [3:0] ST_T_D  = 4'd5;
  localparam logic [3:0] ST_C_P1 = 4'd6;
  localparam logic [3:0] ST_C_P2 = 4'd7;
  localparam logic [3:0] ST_C_S1 = 4'd8;
  localparam logic [3:0] ST_C_S2 = 4'd9;
  localparam logic [3:0] ST_C_SQ = 4'd10;
  localparam logic [3:0] ST_C_DN = 4'd11;
  localparam logic [3:0] ST_C_DV = 4'd12;
  localparam logic [3:0] ST_OUT  = 4'd13;

  localparam logic [31:0] QUARTER = 32'h4000_0000;

  function automatic trig_t trig_prep(logic [31:0] p);
    logic [30:0] w;
    trig_t       t;
    w = {1'b0, p[29:0]};
    if (p[30]) begin
      w = 31'h4000_0000 - w;
    end
    t.u   = w[30:15];
    t.neg = p[31];
    return t;
  endfunction

  function automatic logic [18:0] mag19(logic signed [18:0] v);
    return v[18] ? 19'(-v) : 19'(v);
  endfunction

  logic [3:0]            state_q, state_d;
  logic [15:0]           angle_step_q;
  logic [PHASE_BITS-1:0] phase_q, phase_eff;
  logic [SW-1:0]         phase_sum;
  logic [PHASE_BITS+DB-1:0] idx_wide;
  logic [31:0]           p_acc, p_q;
  logic                  sel_q, first_q, neg_q;
  logic [15:0]           rng_q, x2_q;
  trig_t                 cur_trig, acc_trig, sin_trig;

  logic signed [16:0] x_q, prev_x_q, prev_y_q, val;
  logic signed [17:0] prev_dx_q, prev_dy_q, dx_q, dy_q, dx_n, dy_n;
  logic signed [18:0] d2x_q, d2y_q, d2x_n, d2y_n;
  logic signed [38:0] p1_q, p2_n, num_q;
  logic [36:0]        s_q, s_sum;
  logic [31:0]        res_q;
  logic               res_sat_q;
  logic               out_valid_q;
  logic [31:0]        curv_q;
  logic               sat_q;

  logic          mul_start, mul_busy, mul_done;
  logic [MA-1:0] mul_a;
  logic [MB-1:0] mul_b;
  logic [PW-1:0] prod;
  logic          sq_start, sq_done;
  logic [RW-1:0] root;
  logic          dv_start, dv_done;
  logic [QW-1:0] quo;

  logic [17:0] rr;
  logic [14:0] tmag;
  logic [30:0] vv;
  logic [16:0] vmag;
  logic        accept, out_load, cfg_wr;
  logic [QW-1:0] lim, qclip;
  logic          qsat, num_neg;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  assign phase_eff = first_i ? {1'b1, {(PHASE_BITS-1){1'b0}}} : phase_q;
  assign phase_sum = SW'(phase_eff) + SW'(angle_step_q);
  assign idx_wide  = {phase_eff, {DB{1'b0}}} >> PHASE_BITS;
  assign p_acc     = {idx_wide[DB-1:0], {(32-DB){1'b0}}};
  assign acc_trig  = trig_prep(p_acc + QUARTER);
  assign cur_trig  = trig_prep(sel_q ? p_q : p_q + QUARTER);
  assign sin_trig  = trig_prep(p_q);

  assign rr   = 18'(prod[31:15]) + 18'd2;
  assign tmag = (rr[17:2] > 16'd16384) ? 15'd16384 : rr[16:2];
  assign vv   = 31'(prod[29:0]) + 31'd8192;
  assign vmag = vv[30:14];
  assign val  = neg_q ? -$signed(vmag) : $signed(vmag);

  assign dx_n  = 18'(x_q) - 18'(prev_x_q);
  assign dy_n  = 18'(val) - 18'(prev_y_q);
  assign d2x_n = 19'(dx_n) - 19'(prev_dx_q);
  assign d2y_n = 19'(dy_n) - 19'(prev_dy_q);

  assign p2_n  = (dy_q[17] ^ d2x_q[18]) ? -39'(prod[37:0]) : 39'(prod[37:0]);
  assign s_sum = s_q + prod[36:0];

  assign num_neg = num_q[38];
  assign lim     = num_neg ? QW'(32'h8000_0000) : QW'(32'h7fff_ffff);
  assign qsat    = quo > lim;
  assign qclip   = qsat ? lim : quo;

  always_comb begin
    state_d   = state_q;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    sq_start  = 1'b0;
    dv_start  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          mul_start = 1'b1;
          mul_a     = MA'(acc_trig.u);
          mul_b     = MB'(acc_trig.u);
          state_d   = ST_T_UU;
        end
      end
      ST_T_UU: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = MA'(SIN_C3);
          mul_b     = MB'(prod[30:15]);
          state_d   = ST_T_A;
        end
      end
      ST_T_A: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = MA'(SIN_C2 - prod[30:15]);
          mul_b     = MB'(x2_q);
          state_d   = ST_T_B;
        end
      end
      ST_T_B: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = MA'(cur_trig.u);
          mul_b     = MB'(SIN_C1 - prod[31:15]);
          state_d   = ST_T_C;
        end
      end
      ST_T_C: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = MA'(rng_q);
          mul_b     = MB'(tmag);
          state_d   = ST_T_D;
        end
      end
      ST_T_D: begin
        if (mul_done) begin
          if (!sel_q) begin
            mul_start = 1'b1;
            mul_a     = MA'(sin_trig.u);
            mul_b     = MB'(sin_trig.u);
            state_d   = ST_T_UU;
          end else if (first_q) begin
            state_d = ST_OUT;
          end else begin
            mul_start = 1'b1;
            mul_a     = MA'(mag19(19'(dx_n)));
            mul_b     = MB'(mag19(d2y_n));
            state_d   = ST_C_P1;
          end
        end
      end
      ST_C_P1: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = MA'(mag19(19'(dy_q)));
          mul_b     = MB'(mag19(d2x_q));
          state_d   = ST_C_P2;
        end
      end
      ST_C_P2: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = MA'(mag19(19'(dx_q)));
          mul_b     = MB'(mag19(19'(dx_q)));
          state_d   = ST_C_S1;
        end
      end
      ST_C_S1: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = MA'(mag19(19'(dy_q)));
          mul_b     = MB'(mag19(19'(dy_q)));
          state_d   = ST_C_S2;
        end
      end
      ST_C_S2: begin
        if (mul_done) begin
          if (s_sum == '0) begin
            state_d = ST_OUT;
          end else begin
            sq_start = 1'b1;
            state_d  = ST_C_SQ;
          end
        end
      end
      ST_C_SQ: begin
        if (sq_done) begin
          mul_start = 1'b1;
          mul_a     = s_q;
          mul_b     = root;
          state_d   = ST_C_DN;
        end
      end
      ST_C_DN: begin
        if (mul_done) begin
          dv_start = 1'b1;
          state_d  = ST_C_DV;
        end
      end
      ST_C_DV: begin
        if (dv_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      angle_step_q <= 16'd64;
      phase_q      <= {1'b1, {(PHASE_BITS-1){1'b0}}};
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      prev_dx_q    <= '0;
      prev_dy_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        angle_step_q <= pwdata[15:0];
      end
      if (accept) begin
        phase_q <= phase_sum[PHASE_BITS-1:0];
      end
      if ((state_q == ST_T_D) && mul_done && sel_q) begin
        prev_x_q <= x_q;
        prev_y_q <= val;
        if (first_q) begin
          prev_dx_q <= '0;
          prev_dy_q <= '0;
        end else begin
          prev_dx_q <= dx_n;
          prev_dy_q <= dy_n;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rng_q   <= range_i;
      first_q <= first_i;
      p_q     <= p_acc;
      sel_q   <= 1'b0;
      res_q   <= '0;
      res_sat_q <= 1'b0;
    end
    if (mul_done) begin
      unique case (state_q)
        ST_T_UU: x2_q <= prod[30:15];
        ST_T_C:  neg_q <= cur_trig.neg;
        ST_T_D: begin
          if (!sel_q) begin
            x_q   <= val;
            sel_q <= 1'b1;
          end else begin
            dx_q  <= dx_n;
            dy_q  <= dy_n;
            d2x_q <= d2x_n;
            d2y_q <= d2y_n;
          end
        end
        ST_C_P1: p1_q  <= (dx_q[17] ^ d2y_q[18]) ? -39'(prod[37:0]) : 39'(prod[37:0]);
        ST_C_P2: num_q <= p1_q - p2_n;
        ST_C_S1: s_q   <= prod[36:0];
        ST_C_S2: s_q   <= s_sum;
        default: ;
      endcase
    end
    if ((state_q == ST_C_DV) && dv_done) begin
      res_q     <= num_neg ? 32'(-qclip) : 32'(qclip);
      res_sat_q <= qsat;
    end
    if (out_load) begin
      curv_q <= res_q;
      sat_q  <= res_sat_q;
    end
  end

  scurv_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  scurv_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .v_i     ({s_sum[35:0], 28'b0}),
    .done_o  (sq_done),
    .root_o  (root)
  );

  scurv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .num_i   ({num_neg ? 38'(-num_q) : 38'(num_q), 31'b0} >> 1),
    .den_i   (prod[DENW-1:0]),
    .done_o  (dv_done),
    .quo_o   (quo)
  );

  assign out_valid_o = out_valid_q;
  assign curvature_o = curv_q;
  assign saturated_o = sat_q;
  assign prdata      = paddr[2] ? 32'h0 : {16'h0, angle_step_q};
  assign pready      = 1'b1;

`include "scan_curvature_assert.svh"

  `SC_ASSERT_IMPL(a_idle_mul_quiet, state_q == ST_IDLE, !mul_busy, "multiplier busy while idle")
  `SC_ASSERT_IMPL(a_mul_no_restart, mul_start, !mul_busy || mul_done, "multiplier restarted")
  `SC_ASSERT_NEXT(a_accept_busy, accept, state_q != ST_IDLE, "accept did not start work")
  `SC_ASSERT_IMPL(a_sat_bound, out_valid_o && saturated_o,
    curvature_o == 32'sh7fff_ffff || curvature_o == 32'sh8000_0000, "saturated value off bound")
endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import scurv_pkg::*;

  localparam int unsigned DEPTH  = 1024;
  localparam int unsigned PBITS  = 16;
  localparam logic [15:0] HALF   = 16'h8000;
  localparam logic [2:0]  ADDR_ANGLE_STEP = 3'd0;
  localparam int unsigned LIMIT  = 3000000;
  localparam int unsigned SETTLE = 400;

  typedef struct {
    logic [15:0] rng;
    logic        first;
  } sample_t;

  typedef struct {
    logic signed [31:0] curv;
    logic               sat;
  } curv_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [15:0] range_i = '0;
  logic first_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] curvature_o;
  logic saturated_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  sample_t samples_q[$];
  curv_t   curv_q[$];

  logic [15:0] step_m;
  logic [15:0] phase_m;
  int          px_m, py_m, pdx_m, pdy_m;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;
  bit          hold_req = 0;
  int unsigned errors = 0;
  int unsigned n_in = 0, n_out = 0, n_sat = 0, n_zero = 0;
  int unsigned cycles = 0;
  bit          in_fire;

  scan_curvature dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic logic signed [31:0] sine_q14(logic [31:0] p);
    logic [1:0]  quad;
    logic [63:0] w, u, x2, t, r;
    quad = p[31:30];
    w = {34'd0, p[29:0]};
    if (quad[0]) w = 64'h4000_0000 - w;
    u  = w >> 15;
    x2 = (u * u) >> 15;
    t  = (64'(SIN_C3) * x2) >> 15;
    t  = 64'(SIN_C2) - t;
    t  = (t * x2) >> 15;
    t  = 64'(SIN_C1) - t;
    r  = (u * t) >> 15;
    r  = (r + 2) >> 2;
    if (r > 16384) r = 16384;
    return quad[1] ? -$signed(r[31:0]) : $signed(r[31:0]);
  endfunction

  function automatic int scale_to_axis(logic [15:0] rng, logic signed [31:0] trig);
    longint unsigned mag, v;
    mag = trig < 0 ? longint'(-trig) : longint'(trig);
    v = (64'(rng) * mag + 8192) >> 14;
    return trig < 0 ? -int'(v) : int'(v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  task automatic predict_curvature(sample_t s);
    longint unsigned idx, p, sum_sq, root, mag, q, lim;
    logic [127:0] den, quo;
    logic signed [31:0] sn, cs;
    int x, y, dx, dy, d2x, d2y;
    longint num;
    curv_t e;
    if (s.first) phase_m = HALF;
    idx = (64'(phase_m) * DEPTH) >> PBITS;
    p   = (idx << 32) / DEPTH;
    sn  = sine_q14(p[31:0]);
    cs  = sine_q14(p[31:0] + 32'h4000_0000);
    x   = scale_to_axis(s.rng, cs);
    y   = scale_to_axis(s.rng, sn);
    phase_m = phase_m + step_m;
    e.curv = 0;
    e.sat  = 0;
    if (s.first) begin
      px_m = x; py_m = y; pdx_m = 0; pdy_m = 0;
    end else begin
      dx = x - px_m; dy = y - py_m;
      d2x = dx - pdx_m; d2y = dy - pdy_m;
      px_m = x; py_m = y; pdx_m = dx; pdy_m = dy;
      num = longint'(dx) * d2y - longint'(dy) * d2x;
      sum_sq = longint'(dx) * dx + longint'(dy) * dy;
      if (sum_sq != 0) begin
        root = int_sqrt(sum_sq << 28);
        den  = 128'(sum_sq) * 128'(root);
        mag  = num < 0 ? -num : num;
        quo  = (128'(mag) << 30) / den;
        q    = quo > (128'd1 << 33) ? 64'd1 << 33 : quo[63:0];
        lim  = num < 0 ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (q > lim) begin
          q = lim;
          e.sat = 1;
        end
        e.curv = num < 0 ? -q[31:0] : q[31:0];
      end else begin
        n_zero++;
      end
    end
    curv_q.insert(curv_q.size(), e);
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("%0t timeout, %0d results outstanding", $time, curv_q.size());
      $display("tb_top: errors");
      $finish;
    end
    in_fire = in_valid_i && !in_stall_o;
    if (in_fire) begin
      predict_curvature('{range_i, first_i});
      n_in++;
    end
    if (out_valid_o && !out_stall_i) begin
      n_out++;
      if (saturated_o) n_sat++;
      if (curv_q.size() == 0) begin
        $display("%0t unexpected transaction curv=%0d sat=%0b", $time, curvature_o,
                 saturated_o);
        errors++;
      end else begin
        if (curvature_o !== curv_q[0].curv || saturated_o !== curv_q[0].sat) begin
          $display("%0t mismatch: expected curv=%0d sat=%0b, actual curv=%0d sat=%0b",
                   $time, curv_q[0].curv, curv_q[0].sat, curvature_o, saturated_o);
          errors++;
        end
        void'(curv_q.pop_front());
      end
    end
  end

  // sender
  always @(negedge clk_i) begin
    sample_t s;
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (samples_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        s = samples_q.pop_front();
        range_i <= s.rng;
        first_i <= s.first;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = 800;
      hold_req = 0;
    end else if (hold_left != 0) begin
      hold_left--;
    end
    out_stall_i <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
  end

  task automatic write_angle_step(logic [15:0] v);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_ANGLE_STEP; pwdata <= {16'd0, v};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    step_m = v;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain();
    while (samples_q.size() != 0 || in_valid_i || curv_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic add_sample(logic [15:0] r, logic f);
    sample_t s;
    s.rng   = r;
    s.first = f;
    samples_q.insert(samples_q.size(), s);
  endtask

  task automatic add_scans(int unsigned n);
    int unsigned len, mode, k;
    logic [15:0] base;
    k = 0;
    while (k < n) begin
      len  = $urandom_range(40, 1);
      if (len > n - k) len = n - k;
      mode = $urandom_range(9);
      base = 16'($urandom);
      for (int i = 0; i < len; i++) begin
        logic [15:0] r;
        case (mode)
          0, 1, 2, 3: r = base + 16'($urandom_range(64)) - 16'd32;
          4:          r = base;
          5:          r = $urandom_range(1) ? 16'hFFFF : 16'h0000;
          6:          r = 16'($urandom_range(15));
          default:    r = 16'($urandom);
        endcase
        // occasional broken scan: first flag missing or misplaced
        if (mode == 9) add_sample(r, $urandom_range(7) == 0);
        else add_sample(r, i == 0);
        k++;
      end
    end
  endtask

  initial begin
    logic [15:0] steps[6];
    step_m = 16'd64;
    phase_m = HALF;
    px_m = 0; py_m = 0; pdx_m = 0; pdy_m = 0;
    steps = '{16'd64, 16'd65535, 16'd0, 16'd1, 16'd1024, 16'd0};
    steps[5] = 16'($urandom);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: continuation from reset, extremes, repeated points, large steps
    add_sample(16'd1000, 1'b0);
    add_sample(16'hFFFF, 1'b0);
    add_sample(16'hFFFF, 1'b1);
    add_sample(16'hFFFF, 1'b0);
    add_sample(16'hFFFF, 1'b0);
    add_sample(16'h0000, 1'b0);
    add_sample(16'h0000, 1'b0);
    add_sample(16'h0000, 1'b1);
    add_sample(16'h0000, 1'b0);
    add_sample(16'h0001, 1'b0);
    add_sample(16'h0001, 1'b0);
    add_sample(16'h8000, 1'b1);
    add_sample(16'h7FFF, 1'b0);
    add_sample(16'h8001, 1'b0);
    add_sample(16'h0002, 1'b0);
    add_sample(16'hFFFE, 1'b0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph != 0) write_angle_step(steps[ph]);
      idle_pct  = (ph % 4 == 1 || ph % 4 == 3) ? 80 : 0;
      stall_pct = (ph % 4 == 2) ? 80 : (ph % 4 == 3) ? 32 : 0;
      if (ph % 4 == 3) idle_pct = 32;
      if (ph == 0) hold_req = 1;
      add_scans(205);
      drain();
    end

    $display("covered %0d samples, %0d results (%0d saturated, %0d zero-length steps)",
             n_in, n_out, n_sat, n_zero);
    $display("angle steps 0, 1, 64, 1024, 65535 and 0x%h, with idle and stall mixes",
             steps[5]);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/scurv_pkg.sv
rtl/core/scurv_mul.sv
rtl/core/scurv_sqrt.sv
rtl/core/scurv_div.sv
rtl/core/scan_curvature.sv
bench/tb_top.sv
